### hw/rtl/audio_envelope_smoother_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio envelope smoother
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ENVELOPE_SMOOTHER_UNIT_MACROS_SVH
`define AUDIO_ENVELOPE_SMOOTHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aes check failed");
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aes check failed");
`else
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Types and constants shared by the audio envelope smoother modules.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int LEVEL_W     = 16;
   localparam int Q16_W       = 17;
   localparam int TIME_W      = 40;
   localparam int DELTA_W     = 20;
   localparam int ELAPSED_W   = TIME_W + 1;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int MUL_W       = 18;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ADD_W       = 16;
   localparam int CAP_W       = 17;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_GAIN = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLUX_GAIN   = 4'd1;

   localparam logic [CSR_DATA_W-1:0] ENERGY_GAIN_RESET = 16'd7373;
   localparam logic [CSR_DATA_W-1:0] FLUX_GAIN_RESET   = 16'd20480;

   localparam logic [Q16_W-1:0] ONE_Q16    = 17'd65536;
   localparam logic [ADD_W-1:0] ROUND_HALF = 16'd32768;

   // Q2.30 per-step ratios of the decay tables
   localparam logic [63:0] RATIO_K5 = 64'd1073205087;
   localparam logic [63:0] RATIO_K7 = 64'd1072990468;

   // time-jump thresholds
   localparam logic signed [ELAPSED_W-1:0] ELAPSED_MIN = -41'sd1000;
   localparam logic signed [ELAPSED_W-1:0] ELAPSED_MAX = 41'sd250000;
   localparam logic signed [ELAPSED_W-1:0] ELAPSED_GAP = 41'sd20000;
   localparam logic [DELTA_W-1:0]          DELTA_JUMP  = 20'd200000;
   localparam logic [DELTA_W-1:0]          DELTA_CAP   = 20'd100000;
   localparam logic [CAP_W-1:0]            DELTA_ROUND = 17'd50;

   // ceil(2^24 / 100): exact floor(x / 100) for x below 199728
   localparam logic [MUL_W-1:0] RECIP_100  = 18'd167773;
   localparam int               RECIP_SHIFT = 24;
   localparam int               QUOT_W      = 12;

   typedef struct packed {
      logic [LEVEL_W-1:0] rms_level;
      logic [LEVEL_W-1:0] flux_level;
      logic               onset_flag;
      logic [TIME_W-1:0]  timestamp_us;
      logic [DELTA_W-1:0] frame_delta_us;
   } req_type;

   typedef struct packed {
      logic [Q16_W-1:0] energy_out;
      logic [Q16_W-1:0] flux_out;
      logic [Q16_W-1:0] pulse_out;
      logic             rebased;
   } rsp_type;

endpackage

### hw/rtl/aes_exp_rom.sv
// ----------------------------------------------------------------------------
// aes_exp_rom
// Decay tables exp(-5*t) and exp(-7*t) in 100 us steps, Q1.16, registered read.
// ----------------------------------------------------------------------------
module aes_exp_rom #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   output logic [aes_pkg::Q16_W-1:0]  exp5_data,
   output logic [aes_pkg::Q16_W-1:0]  exp7_data
);
   import aes_pkg::*;

   typedef logic [Q16_W-1:0] rom_type [DEPTH];

   // repeated Q2.30 multiply, round half up each step
   function automatic rom_type build_rom(input logic [63:0] ratio);
      rom_type     rom;
      logic [63:0] v;
      v = 64'd1 << 30;
      for (int i = 0; i < DEPTH; i++) begin
         rom[i] = Q16_W'((v + (64'd1 << 13)) >> 14);
         v = (v * ratio + (64'd1 << 29)) >> 30;
      end
      return rom;
   endfunction

   localparam rom_type EXP5_ROM = build_rom(RATIO_K5);
   localparam rom_type EXP7_ROM = build_rom(RATIO_K7);

   logic [Q16_W-1:0] exp5_ff;
   logic [Q16_W-1:0] exp7_ff;

   always_ff @(posedge clock) begin
      exp5_ff <= EXP5_ROM[addr];
      exp7_ff <= EXP7_ROM[addr];
   end

   assign exp5_data = exp5_ff;
   assign exp7_data = exp7_ff;

endmodule

### hw/rtl/aes_mul.sv
// ----------------------------------------------------------------------------
// aes_mul
// Shared 18x18 multiplier with addend, used for every product of the step.
// ----------------------------------------------------------------------------
module aes_mul (
   input  logic [aes_pkg::MUL_W-1:0]  mul_a,
   input  logic [aes_pkg::MUL_W-1:0]  mul_b,
   input  logic [aes_pkg::ADD_W-1:0]  mul_add,
   output logic [aes_pkg::PROD_W-1:0] mul_result
);
   import aes_pkg::*;

   // max (2^18-1)^2 + 2^16 still fits in PROD_W bits
   assign mul_result = PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(mul_add);

endmodule

### hw/rtl/audio_envelope_smoother_unit.sv
// ----------------------------------------------------------------------------
// audio_envelope_smoother_unit
// Variable-timestep one-pole smoother for frame energy, flux and onset pulse.
// ----------------------------------------------------------------------------
// From acceptance to its transaction on rsp, a frame has the single 18x18
// multiplier form both targets, the table index, both smoother steps and
// the pulse decay one after another, with the registered decay-table read
// before the smoother steps; a frame that rebases or carries a zero delta
// stops after the targets. req_stall is high while a frame is in flight; a
// result may wait on rsp_stall while the next frame is accepted and worked
// on. Configuration writes are always taken.
`include "audio_envelope_smoother_unit_macros.svh"

module audio_envelope_smoother_unit #(
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  aes_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output aes_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aes_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aes_pkg::CSR_DATA_W-1:0]    csr_data
);
   import aes_pkg::*;

   localparam int               IDX_W   = $clog2(EXP_TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(EXP_TABLE_DEPTH - 1);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_TGT_E    = 4'd1;
   localparam logic [3:0] ST_TGT_F    = 4'd2;
   localparam logic [3:0] ST_INDEX    = 4'd3;
   localparam logic [3:0] ST_ROM      = 4'd4;
   localparam logic [3:0] ST_SMOOTH_E = 4'd5;
   localparam logic [3:0] ST_SMOOTH_F = 4'd6;
   localparam logic [3:0] ST_PULSE    = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0]            state_ff;
   logic [3:0]            state_in;
   req_type               req_ff;
   logic [CSR_DATA_W-1:0] energy_gain_ff;
   logic [CSR_DATA_W-1:0] flux_gain_ff;
   logic [Q16_W-1:0]      energy_level_ff;
   logic [Q16_W-1:0]      flux_state_ff;
   logic [Q16_W-1:0]      pulse_level_ff;
   logic [TIME_W-1:0]     previous_time_ff;
   logic                  started_ff;
   logic [Q16_W-1:0]      e_tgt_ff;
   logic [Q16_W-1:0]      f_tgt_ff;
   logic                  jump_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [ADD_W-1:0]      mul_add;
   logic [PROD_W-1:0]     mul_result;
   logic [Q16_W-1:0]      exp5_data;
   logic [Q16_W-1:0]      exp7_data;

   logic                  req_fire;
   logic                  done_fire;
   logic signed [ELAPSED_W-1:0] elapsed;
   logic                  jump_c;
   logic [Q16_W-1:0]      tgt_sat;
   logic [CAP_W-1:0]      delta_cap;
   logic [QUOT_W-1:0]     quot;
   logic [IDX_W-1:0]      idx_sat;
   logic [Q16_W-1:0]      blend;
   logic [Q16_W-1:0]      diff_e;
   logic [Q16_W-1:0]      diff_f;
   logic [Q16_W-1:0]      step;
   logic [Q16_W-1:0]      energy_new;
   logic [Q16_W-1:0]      flux_new;
   logic [Q16_W-1:0]      fin_energy;
   logic [Q16_W-1:0]      fin_flux;
   logic [Q16_W-1:0]      fin_pulse;

   aes_mul u_mul (
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_add    (mul_add),
      .mul_result (mul_result)
   );

   aes_exp_rom #(
      .DEPTH (EXP_TABLE_DEPTH)
   ) u_rom (
      .clock     (clock),
      .addr      (idx_ff),
      .exp5_data (exp5_data),
      .exp7_data (exp7_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // time-jump detection
   assign elapsed = $signed({1'b0, req_ff.timestamp_us}) - $signed({1'b0, previous_time_ff});
   assign jump_c  = !started_ff || (elapsed < ELAPSED_MIN) || (elapsed > ELAPSED_MAX) ||
                    (req_ff.frame_delta_us > DELTA_JUMP) ||
                    ((elapsed > ELAPSED_GAP) && (req_ff.frame_delta_us == '0));

   assign delta_cap = (req_ff.frame_delta_us > DELTA_CAP) ? CAP_W'(DELTA_CAP)
                                                          : req_ff.frame_delta_us[CAP_W-1:0];
   assign quot      = mul_result[RECIP_SHIFT +: QUOT_W];
   assign idx_sat   = (quot > QUOT_W'(EXP_TABLE_DEPTH - 1)) ? IDX_MAX : quot[IDX_W-1:0];

   // target = (level * gain) >> 12, saturated to 1.0
   assign tgt_sat = (mul_result[31:12] > 20'(ONE_Q16)) ? ONE_Q16 : mul_result[28:12];

   assign blend  = ONE_Q16 - exp5_data;
   assign diff_e = (e_tgt_ff >= energy_level_ff) ? e_tgt_ff - energy_level_ff
                                                 : energy_level_ff - e_tgt_ff;
   assign diff_f = (f_tgt_ff >= flux_state_ff) ? f_tgt_ff - flux_state_ff
                                               : flux_state_ff - f_tgt_ff;
   assign step   = mul_result[16 +: Q16_W];

   assign energy_new = (e_tgt_ff >= energy_level_ff) ? energy_level_ff + step
                                                     : energy_level_ff - step;
   assign flux_new   = (f_tgt_ff >= flux_state_ff) ? flux_state_ff + step
                                                   : flux_state_ff - step;

   assign fin_energy = jump_ff ? e_tgt_ff : energy_level_ff;
   assign fin_flux   = jump_ff ? f_tgt_ff : flux_state_ff;
   assign fin_pulse  = jump_ff ? (req_ff.onset_flag ? ONE_Q16 : '0) : pulse_level_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_add = '0;
      case (state_ff)
         ST_TGT_E: begin
            mul_a = MUL_W'(req_ff.rms_level);
            mul_b = MUL_W'(energy_gain_ff);
         end
         ST_TGT_F: begin
            mul_a = MUL_W'(req_ff.flux_level);
            mul_b = MUL_W'(flux_gain_ff);
         end
         ST_INDEX: begin
            mul_a = MUL_W'(delta_cap + DELTA_ROUND);
            mul_b = RECIP_100;
         end
         ST_SMOOTH_E: begin
            mul_a   = MUL_W'(diff_e);
            mul_b   = MUL_W'(blend);
            mul_add = ROUND_HALF;
         end
         ST_SMOOTH_F: begin
            mul_a   = MUL_W'(diff_f);
            mul_b   = MUL_W'(blend);
            mul_add = ROUND_HALF;
         end
         ST_PULSE: begin
            mul_a   = MUL_W'(pulse_level_ff);
            mul_b   = MUL_W'(exp7_data);
            mul_add = ROUND_HALF;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_TGT_E;
         ST_TGT_E:    state_in = ST_TGT_F;
         ST_TGT_F: begin
            if (jump_ff || (req_ff.frame_delta_us == '0)) state_in = ST_DONE;
            else state_in = ST_INDEX;
         end
         ST_INDEX:    state_in = ST_ROM;
         ST_ROM:      state_in = ST_SMOOTH_E;
         ST_SMOOTH_E: state_in = ST_SMOOTH_F;
         ST_SMOOTH_F: state_in = ST_PULSE;
         ST_PULSE:    state_in = ST_DONE;
         ST_DONE:     if (done_fire) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         energy_gain_ff   <= ENERGY_GAIN_RESET;
         flux_gain_ff     <= FLUX_GAIN_RESET;
         energy_level_ff  <= '0;
         flux_state_ff    <= '0;
         pulse_level_ff   <= '0;
         previous_time_ff <= '0;
         started_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ENERGY_GAIN: energy_gain_ff <= csr_data;
               CSR_FLUX_GAIN:   flux_gain_ff   <= csr_data;
               default: begin
               end
            endcase
         end

         case (state_ff)
            ST_SMOOTH_E: energy_level_ff <= energy_new;
            ST_SMOOTH_F: flux_state_ff   <= flux_new;
            ST_PULSE:    pulse_level_ff  <= req_ff.onset_flag ? ONE_Q16 : step;
            default: begin
            end
         endcase

         if (done_fire) begin
            energy_level_ff  <= fin_energy;
            flux_state_ff    <= fin_flux;
            pulse_level_ff   <= fin_pulse;
            previous_time_ff <= req_ff.timestamp_us;
            started_ff       <= 1'b1;
         end

         rsp_valid_ff <= done_fire || (rsp_valid_ff && rsp_stall);
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_data;
      if (state_ff == ST_TGT_E) begin
         e_tgt_ff <= tgt_sat;
         jump_ff  <= jump_c;
      end
      if (state_ff == ST_TGT_F) f_tgt_ff <= tgt_sat;
      if (state_ff == ST_INDEX) idx_ff <= idx_sat;
      if (done_fire) begin
         rsp_ff.energy_out <= fin_energy;
         rsp_ff.flux_out   <= fin_flux;
         rsp_ff.pulse_out  <= fin_pulse;
         rsp_ff.rebased    <= jump_ff;
      end
   end

   `AES_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == ST_TGT_E)
   `AES_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `AES_ASSERT_IMPL(a_rsp_started, clock, reset, rsp_valid_ff, started_ff)
   `AES_ASSERT_IMPL(a_energy_range, clock, reset, 1'b1, energy_level_ff <= ONE_Q16)
   `AES_ASSERT_IMPL(a_pulse_range, clock, reset, 1'b1, pulse_level_ff <= ONE_Q16)

endmodule

### dv/audio_envelope_smoother_unit_tb.sv
// ----------------------------------------------------------------------------
// audio_envelope_smoother_unit_tb
// Self-checking bench for the envelope smoother. Frames are driven from a
// backlog, a transaction-level predictor models energy, flux and onset pulse per
// accepted frame, and every result transaction is checked against the oldest
// prediction. Gains are reprogrammed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module audio_envelope_smoother_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aes_pkg::*;

   localparam int TABLE_DEPTH    = 1024;
   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 4;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int END_SETTLE     = 30;
   localparam int MAX_REPORTS    = 40;
   localparam int PHASE_ITEMS    = 250;

   // no register lives at this index; writes must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'hF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   audio_envelope_smoother_unit #(
      .EXP_TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // predictor state
   logic [Q16_W-1:0]      exp5_lut [TABLE_DEPTH];
   logic [Q16_W-1:0]      exp7_lut [TABLE_DEPTH];
   logic [CSR_DATA_W-1:0] energy_gain_q = ENERGY_GAIN_RESET;
   logic [CSR_DATA_W-1:0] flux_gain_q = FLUX_GAIN_RESET;
   logic [Q16_W-1:0]      energy_track = '0;
   logic [Q16_W-1:0]      flux_track = '0;
   logic [Q16_W-1:0]      pulse_track = '0;
   logic [TIME_W-1:0]     last_stamp = '0;
   logic                  primed = 1'b0;

   req_type     frame_backlog [$];
   rsp_type     pending_envelopes [$];
   logic [TIME_W-1:0] stim_time = '0;
   int          frames_queued = 0;
   int          envelopes_seen = 0;
   int          error_count = 0;
   int          send_pct = 0;
   int          recv_pct = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_asks = 0;
   int          hold_grants = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   // decay tables: repeated Q2.30 products, rounded to Q1.16
   function automatic void build_decay_luts();
      bit [63:0] v5;
      bit [63:0] v7;
      v5 = 64'd1 << 30;
      v7 = 64'd1 << 30;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         exp5_lut[i] = Q16_W'((v5 + (64'd1 << 13)) >> 14);
         exp7_lut[i] = Q16_W'((v7 + (64'd1 << 13)) >> 14);
         v5 = (v5 * RATIO_K5 + (64'd1 << 29)) >> 30;
         v7 = (v7 * RATIO_K7 + (64'd1 << 29)) >> 30;
      end
   endfunction

   function automatic logic [Q16_W-1:0] gain_target(logic [LEVEL_W-1:0] lvl,
                                                    logic [CSR_DATA_W-1:0] g);
      bit [63:0] t;
      t = (64'(lvl) * 64'(g)) >> 12;
      return (t > 64'(ONE_Q16)) ? ONE_Q16 : Q16_W'(t);
   endfunction

   // one-pole step toward the target, never overshooting it
   function automatic logic [Q16_W-1:0] glide(logic [Q16_W-1:0] s, logic [Q16_W-1:0] t,
                                              logic [Q16_W-1:0] blend);
      bit [63:0] step;
      if (t >= s) begin
         step = (64'(t - s) * 64'(blend) + 64'd32768) >> 16;
         return s + Q16_W'(step);
      end
      step = (64'(s - t) * 64'(blend) + 64'd32768) >> 16;
      return s - Q16_W'(step);
   endfunction

   function automatic rsp_type smooth_frame(req_type f);
      longint            elapsed;
      longint            mag;
      logic [Q16_W-1:0]  e_t;
      logic [Q16_W-1:0]  f_t;
      logic [Q16_W-1:0]  blend;
      logic [DELTA_W-1:0] dt;
      int                idx;
      logic              jump;
      rsp_type           r;
      elapsed = longint'({24'd0, f.timestamp_us}) - longint'({24'd0, last_stamp});
      mag = (elapsed < 0) ? -elapsed : elapsed;
      e_t = gain_target(f.rms_level, energy_gain_q);
      f_t = gain_target(f.flux_level, flux_gain_q);
      dt = f.frame_delta_us;
      jump = !primed || elapsed < longint'(ELAPSED_MIN) || elapsed > longint'(ELAPSED_MAX) ||
             dt > DELTA_JUMP || (mag > longint'(ELAPSED_GAP) && dt == '0);
      last_stamp = f.timestamp_us;
      if (jump) begin
         energy_track = e_t;
         flux_track = f_t;
         pulse_track = f.onset_flag ? ONE_Q16 : '0;
         primed = 1'b1;
      end else if (dt != '0) begin
         if (dt > DELTA_CAP) dt = DELTA_CAP;
         idx = (int'(dt) + int'(DELTA_ROUND)) / 100;
         if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
         blend = ONE_Q16 - exp5_lut[idx];
         energy_track = glide(energy_track, e_t, blend);
         flux_track = glide(flux_track, f_t, blend);
         pulse_track = Q16_W'((64'(pulse_track) * 64'(exp7_lut[idx]) + 64'd32768) >> 16);
         if (f.onset_flag) pulse_track = ONE_Q16;
      end
      r.energy_out = energy_track;
      r.flux_out = flux_track;
      r.pulse_out = pulse_track;
      r.rebased = jump;
      return r;
   endfunction

   task automatic flag_field(input string name, input int unsigned want,
                             input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : driver_proc
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) pending_envelopes.push_back(smooth_frame(req_data));
         if (!req_valid || taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (frame_backlog.size() != 0) begin
               req_data <= frame_backlog.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) < send_pct) send_gap = $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin : monitor_proc
      rsp_type want;
      logic    hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            envelopes_seen <= envelopes_seen + 1;
            if (pending_envelopes.size() == 0) begin
               error_count++;
               $display("%0t: result transaction with nothing expected, actual %h",
                        $time, rsp_data);
            end else begin
               want = pending_envelopes.pop_front();
               flag_field("energy_out", 32'(want.energy_out), 32'(rsp_data.energy_out));
               flag_field("flux_out", 32'(want.flux_out), 32'(rsp_data.flux_out));
               flag_field("pulse_out", 32'(want.pulse_out), 32'(rsp_data.pulse_out));
               flag_field("rebased", 32'(want.rebased), 32'(rsp_data.rebased));
            end
         end
         if (hold_asks > hold_grants) begin
            hold_grants++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            hold = 1'b1;
         end else if ($urandom_range(0, 99) < recv_pct) begin
            recv_gap = $urandom_range(0, 12);
            hold = 1'b1;
         end else begin
            hold = 1'b0;
         end
         rsp_stall <= hold;
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("audio_envelope_smoother_unit regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ENERGY_GAIN) energy_gain_q = val;
      else if (idx == CSR_FLUX_GAIN) flux_gain_q = val;
      @(posedge clock);
   endtask

   // returns at a rising edge once every queued frame has produced its result
   task automatic wait_drained();
      do @(posedge clock); while (envelopes_seen < frames_queued);
   endtask

   // hop is the signed step from the previous frame's timestamp
   task automatic queue_frame(input logic [LEVEL_W-1:0] rms, input logic [LEVEL_W-1:0] flux,
                              input logic onset, input longint hop,
                              input logic [DELTA_W-1:0] delta);
      req_type f;
      stim_time = stim_time + TIME_W'(hop);
      f.rms_level = rms;
      f.flux_level = flux;
      f.onset_flag = onset;
      f.timestamp_us = stim_time;
      f.frame_delta_us = delta;
      frame_backlog.push_back(f);
      frames_queued++;
   endtask

   function automatic longint hop_to(logic [TIME_W-1:0] stamp);
      return longint'({24'd0, stamp}) - longint'({24'd0, stim_time});
   endfunction

   function automatic logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(0, 3))
         0, 1:    return LEVEL_W'($urandom);
         2:       return LEVEL_W'($urandom_range(0, 4095));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic queue_random_frame();
      int                 pick;
      int                 cls;
      longint             hop;
      logic [DELTA_W-1:0] delta;
      logic [TIME_W-1:0]  stamp;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         // steady frame stream: timestamp follows the delta, sometimes jittered
         cls = $urandom_range(0, 19);
         if (cls == 0) delta = DELTA_W'($urandom_range(1, 49));
         else if (cls <= 8) delta = DELTA_W'($urandom_range(50, 3000));
         else if (cls <= 14) delta = DELTA_W'($urandom_range(3001, 30000));
         else if (cls <= 17) delta = DELTA_W'($urandom_range(30001, 100000));
         else delta = DELTA_W'($urandom_range(100001, 200000));
         hop = longint'(delta);
         if ($urandom_range(0, 3) == 0) hop = hop + longint'($urandom_range(0, 800)) - 400;
      end else if (pick < 82) begin
         delta = '0;
         hop = longint'($urandom_range(0, 26000)) - 3000;
      end else if (pick < 92) begin
         case ($urandom_range(0, 8))
            0: hop = -1001;
            1: hop = -1000;
            2: hop = -999;
            3: hop = 249999;
            4: hop = 250000;
            5: hop = 250001;
            6: hop = 20000;
            7: hop = 20001;
            default: hop = -20001;
         endcase
         case ($urandom_range(0, 8))
            0: delta = '0;
            1: delta = 20'd199999;
            2: delta = 20'd200000;
            3: delta = 20'd200001;
            4: delta = 20'd100000;
            5: delta = 20'd100001;
            6: delta = 20'hFFFFF;
            7: delta = 20'd49;
            default: delta = 20'd50;
         endcase
      end else begin
         stamp = {8'($urandom), $urandom};
         hop = hop_to(stamp);
         delta = DELTA_W'($urandom);
      end
      queue_frame(random_level(), random_level(), $urandom_range(0, 4) == 0, hop, delta);
   endtask

   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] e_gain,
                                   input logic [CSR_DATA_W-1:0] f_gain,
                                   input int s_pct, input int r_pct, input bit long_hold);
      wait_drained();
      write_csr(CSR_ENERGY_GAIN, e_gain);
      write_csr(CSR_FLUX_GAIN, f_gain);
      @(negedge clock);
      send_pct = s_pct;
      recv_pct = r_pct;
      if (long_hold) hold_asks++;
      repeat (PHASE_ITEMS) queue_random_frame();
   endtask

   initial begin
      build_decay_luts();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset gains first, then timing corner cases
      @(negedge clock);
      send_pct = 25;
      recv_pct = 25;
      queue_frame(16'hFFFF, 16'hFFFF, 1'b1, 1000, 20'd0);       // first frame rebases
      queue_frame(16'h0000, 16'h0000, 1'b0, 10000, 20'd10000);
      queue_frame(16'd8000, 16'd3000, 1'b1, 30, 20'd30);        // short delta, index 0
      queue_frame(16'd8000, 16'd3000, 1'b0, 5000, 20'd0);       // zero delta holds levels
      queue_frame(16'd8000, 16'd3000, 1'b0, 20000, 20'd0);
      queue_frame(16'd8000, 16'd3000, 1'b0, 20001, 20'd0);      // gap with no delta
      queue_frame(16'd40000, 16'd1000, 1'b0, 150000, 20'd150000);  // delta capped
      queue_frame(16'd1000, 16'd40000, 1'b1, 200000, 20'd200000);
      queue_frame(16'd1000, 16'd40000, 1'b0, 200001, 20'd200001);
      queue_frame(16'd5000, 16'd5000, 1'b0, -1000, 20'd100);
      queue_frame(16'd5000, 16'd5000, 1'b0, -1001, 20'd100);
      queue_frame(16'd20000, 16'd100, 1'b0, 250000, 20'd50000);
      queue_frame(16'd20000, 16'd100, 1'b1, 250001, 20'd50000);
      queue_frame(16'h0000, 16'hFFFF, 1'b0, 49, 20'd49);
      queue_frame(16'h0000, 16'hFFFF, 1'b0, 50, 20'd50);
      queue_frame(16'h0000, 16'hFFFF, 1'b0, 149, 20'd149);
      queue_frame(16'h0000, 16'hFFFF, 1'b0, 150, 20'd150);
      queue_frame(16'h1234, 16'h4321, 1'b1, hop_to(40'hFF_FFFF_FFFF), 20'hFFFFF);
      queue_frame(16'h8000, 16'h0001, 1'b0, hop_to(40'h00_0000_0000), 20'd100);
      queue_frame(16'hFFFF, 16'h0000, 1'b1, -20001, 20'd0);

      wait_drained();
      write_csr(CSR_ENERGY_GAIN, 16'hFFFF);
      write_csr(CSR_FLUX_GAIN, 16'h0001);
      @(negedge clock);
      queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1000, 20'd1000);
      queue_frame(16'h0001, 16'h0001, 1'b0, 2000, 20'd2000);

      wait_drained();
      write_csr(CSR_ENERGY_GAIN, 16'h0000);
      write_csr(CSR_FLUX_GAIN, 16'hFFFF);
      write_csr(CSR_UNMAPPED, 16'hFFFF);
      @(negedge clock);
      queue_frame(16'hFFFF, 16'h0001, 1'b1, 500, 20'd500);
      queue_frame(16'hAAAA, 16'h5555, 1'b0, 3000, 20'd3000);

      // random phases; the receiver holds off for a long stretch in the first
      run_random_phase(16'($urandom), 16'($urandom), 30, 30, 1'b1);
      run_random_phase(16'd4096, 16'd4096, 50, 50, 1'b0);
      run_random_phase(16'hFFFF, 16'hFFFF, 15, 40, 1'b0);
      run_random_phase(16'h0000, 16'($urandom), 40, 10, 1'b0);
      run_random_phase(ENERGY_GAIN_RESET, FLUX_GAIN_RESET, 0, 0, 1'b0);

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (pending_envelopes.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, pending_envelopes.size());
      end
      if (error_count == 0) begin
         $display("audio_envelope_smoother_unit regression: pass");
      end else begin
         $display("audio_envelope_smoother_unit regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_exp_rom.sv
hw/rtl/aes_mul.sv
hw/rtl/audio_envelope_smoother_unit.sv
dv/audio_envelope_smoother_unit_tb.sv
